### rtl/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants of the insertion sort engine
// Holds the data width, the default capacity and the cell control struct.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned DefCapacity = 64;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;    // insert the broadcast value this cycle
    logic drain_en;  // shift the whole chain one cell toward the head
  } cell_ctrl_t;

endpackage

### rtl/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine: streaming insertion sorter for signed 32-bit values
// A chain of CAPACITY cells keeps the batch in ascending order while it
// arrives; the batch is emitted once the item flagged by tlast is taken.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one signed value per item in s_axis_tdata, tlast marks the
//   final item of a batch. While filling, an item is taken every cycle; each
//   value is placed by all cells comparing in parallel. Values arriving
//   while all CAPACITY cells are full are dropped.
//   Once the tlast item is taken, tready drops and the chain shifts toward
//   its head, one item per cycle while the output is accepted, into the
//   output register. Entering the drain sets draining_q; the first drain
//   step then loads the head item into the output register and raises
//   m_axis_tvalid. Items come in ascending order, equal values in arrival
//   order, the final one with m_axis_tlast. The drain rate is one item per
//   cycle while m_axis_tready allows, set by the single shift port at the
//   head.
//   When m_axis_tready is low the drain holds and the output item stays
//   put. The next batch may start filling while the last output item waits.
//   Reset empties the chain and the output register at once; there is no
//   clearing pass.
// ----------------------------------------------------------------------------
module insertion_sort_engine
  import ise_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic signed [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic                    s_axis_tlast,   // last_in
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic signed [DataW-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic                    m_axis_tlast    // last_out
);

  logic signed [DataW-1:0] cell_val   [CAPACITY];
  logic                    cell_valid [CAPACITY];
  logic                    cell_gt    [CAPACITY];

  cell_ctrl_t              ctrl;
  logic                    draining_q;
  logic                    in_acc;
  logic                    drain_step;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_data_q;
  logic                    out_last_q;

  // Accept while filling; drop values once the tail cell is occupied
  assign s_axis_tready = !draining_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign drain_step    = draining_q && (!out_valid_q || m_axis_tready);

  assign ctrl = cell_ctrl_t'{
    ins_en:   in_acc && !cell_valid[CAPACITY-1],
    drain_en: drain_step
  };

  // Build the chain; the head sees an empty-but-valid left edge
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] l_val;
    logic                    l_valid;
    logic                    l_gt;
    logic signed [DataW-1:0] r_val;
    logic                    r_valid;

    if (i == 0) begin : g_head
      assign l_val   = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_val   = cell_val[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_link
      assign r_val   = cell_val[i+1];
      assign r_valid = cell_valid[i+1];
    end

    ise_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_val_i     (s_axis_tdata),
      .left_val_i    (l_val),
      .left_valid_i  (l_valid),
      .left_gt_i     (l_gt),
      .right_val_i   (r_val),
      .right_valid_i (r_valid),
      .val_o         (cell_val[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // Enter drain on the batch end, leave when the head hands off the final item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && s_axis_tlast) begin
        draining_q <= 1'b1;
      end else if (drain_step && !cell_valid[1]) begin
        draining_q <= 1'b0;
      end
      if (drain_step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output item from the head cell
  always_ff @(posedge clk_i) begin
    if (drain_step) begin
      out_data_q <= cell_val[0];
      out_last_q <= !cell_valid[1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/ise_cell.sv
// ----------------------------------------------------------------------------
// ise_cell: one slot of the sorted chain
// Holds one value and its valid bit; takes the new value, the left
// neighbor's value on insert, or the right neighbor's value on drain.
// ----------------------------------------------------------------------------
module ise_cell
  import ise_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] new_val_i,
  input  logic signed [DataW-1:0] left_val_i,
  input  logic                    left_valid_i,
  input  logic                    left_gt_i,
  input  logic signed [DataW-1:0] right_val_i,
  input  logic                    right_valid_i,
  output logic signed [DataW-1:0] val_o,
  output logic                    valid_o,
  output logic                    gt_o
);

  logic signed [DataW-1:0] val_q;
  logic                    valid_q;
  logic                    take_new;

  // Stored value sorts after the new one; equal values stay ahead
  assign gt_o     = valid_q && (val_q > new_val_i);
  // Every cell that is greater, or the first empty one; a greater left neighbor takes precedence
  assign take_new = gt_o || (!valid_q && left_valid_i);

  // Valid bit: fill on insert, follow the right neighbor on drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.drain_en) begin
      valid_q <= right_valid_i;
    end else if (ctrl_i.ins_en && (left_gt_i || take_new)) begin
      valid_q <= 1'b1;
    end
  end

  // Value: follow the right neighbor on drain; on insert shift right past the insert point, or take the new value
  always_ff @(posedge clk_i) begin
    if (ctrl_i.drain_en) begin
      val_q <= right_val_i;
    end else if (ctrl_i.ins_en) begin
      if (left_gt_i) begin
        val_q <= left_val_i;
      end else if (take_new) begin
        val_q <= new_val_i;
      end
    end
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule
